// ===== hw/rtl/aspt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Address segment policy table package
// Table dimensions, field layout, codes and the item passed along the cells.
// ----------------------------------------------------------------------------
package aspt_pkg;

   localparam int ENTRIES      = 16;
   localparam int ADDR_BITS    = 48;
   localparam int STRIPE_SHIFT = 8;
   localparam int IDX_BITS     = $clog2(ENTRIES);
   localparam int END_BITS     = ADDR_BITS + 1;

   localparam int REQ_DATA_BITS = 104;
   localparam int RSP_DATA_BITS = 40;
   localparam int REQ_ADDR_LSB  = 0;
   localparam int REQ_LEN_LSB   = 48;
   localparam int REQ_POL_LSB   = 96;

   typedef enum logic [1:0] {
      MODE_CREATE = 2'd0,
      MODE_ASSIGN = 2'd1,
      MODE_LOOKUP = 2'd2
   } mode_type;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_MISS    = 2'd1;
   localparam logic [1:0] STATUS_OVERLAP = 2'd2;
   localparam logic [1:0] STATUS_FULL    = 2'd3;

   localparam logic [3:0] POL_DIRECTORY     = 4'd0;
   localparam logic [3:0] POL_ATOMIC_UPDATE = 4'd1;
   localparam logic [3:0] POL_SUBSCRIPTION  = 4'd2;
   localparam logic [3:0] POL_ATOMIC_SWAP   = 4'd3;

   localparam logic CSR_APP_CORE_COUNT = 1'b0;
   localparam logic CSR_HELPER_LOG2    = 1'b1;

   typedef struct packed {
      logic                 valid;
      mode_type             mode;
      logic [ADDR_BITS-1:0] addr;
      logic [END_BITS-1:0]  seg_end;
      logic [3:0]           pol;
      logic                 found;
      logic [3:0]           hit_pol;
      logic [15:0]          hit_id;
      logic                 overlap;
      logic                 free_found;
      logic [IDX_BITS-1:0]  free_idx;
   } token_type;

   typedef struct packed {
      logic                 we;
      logic [IDX_BITS-1:0]  idx;
      logic [ADDR_BITS-1:0] start;
      logic [END_BITS-1:0]  seg_end;
      logic [15:0]          id;
   } commit_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  pol;
      logic [15:0] id;
      logic        bypass;
      logic        home_valid;
      logic [10:0] home_node;
   } result_type;

endpackage

// ===== hw/rtl/aspt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment table cell
// Holds one segment; checks the passing item against it and hands it on.
// ----------------------------------------------------------------------------
module aspt_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [aspt_pkg::IDX_BITS-1:0] cell_idx,
   input  aspt_pkg::token_type           tok_in,
   input  aspt_pkg::commit_type          commit,
   output aspt_pkg::token_type           tok_out
);
   import aspt_pkg::*;

   logic                 valid_ff, valid_in;
   logic [ADDR_BITS-1:0] start_ff, start_in;
   logic [END_BITS-1:0]  end_ff, end_in;
   logic [3:0]           pol_ff, pol_in;
   logic [15:0]          id_ff, id_in;
   logic                 tvalid_ff, tvalid_in;
   token_type            tok_ff, tok_in_nx;
   logic                 hit;
   logic                 commit_here;

   assign hit = valid_ff && (start_ff <= tok_in.addr) && ({1'b0, tok_in.addr} < end_ff);
   assign commit_here = commit.we && (commit.idx == cell_idx);

   always_comb begin
      tok_in_nx = tok_in;
      valid_in  = valid_ff;
      start_in  = start_ff;
      end_in    = end_ff;
      pol_in    = pol_ff;
      id_in     = id_ff;
      tvalid_in = tok_in.valid;
      if (tok_in.valid) begin
         unique case (tok_in.mode)
            MODE_CREATE: begin
               if (valid_ff && ({1'b0, tok_in.addr} < end_ff) &&
                   ({1'b0, start_ff} < tok_in.seg_end)) begin
                  tok_in_nx.overlap = 1'b1;
               end
               if (!valid_ff && !tok_in.free_found) begin
                  tok_in_nx.free_found = 1'b1;
                  tok_in_nx.free_idx   = cell_idx;
               end
            end
            MODE_ASSIGN: begin
               if (hit && !tok_in.found) begin
                  tok_in_nx.found   = 1'b1;
                  tok_in_nx.hit_pol = tok_in.pol;
                  tok_in_nx.hit_id  = id_ff;
                  pol_in            = tok_in.pol;
               end
            end
            MODE_LOOKUP: begin
               if (hit && !tok_in.found) begin
                  tok_in_nx.found   = 1'b1;
                  tok_in_nx.hit_pol = pol_ff;
                  tok_in_nx.hit_id  = id_ff;
               end
            end
            default: begin
            end
         endcase
      end
      if (commit_here) begin
         valid_in = 1'b1;
         start_in = commit.start;
         end_in   = commit.seg_end;
         pol_in   = POL_DIRECTORY;
         id_in    = commit.id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         tvalid_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         tvalid_ff <= tvalid_in;
      end
      start_ff <= start_in;
      end_ff   <= end_in;
      pol_ff   <= pol_in;
      id_ff    <= id_in;
      tok_ff   <= tok_in_nx;
   end

   always_comb begin
      tok_out       = tok_ff;
      tok_out.valid = tvalid_ff;
   end

endmodule

// ===== hw/rtl/address_segment_policy_table_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Address segment policy table
// Segment table built as a row of cells; each item walks the row, one cell a
// cycle, and creates are committed to the claimed free cell at its end.
// ----------------------------------------------------------------------------
// Each accepted item passes the registers of all cells before its result forms.
// A new item is taken only once the last has left the row and the skid is empty.
// A finished result waits in an output register, a second in a skid stage.
// Reset: synchronous; clears all segments, the id counter and the registers
// (app_core_count 1, helper_count_log2 0). No clearing pass is needed.
// ----------------------------------------------------------------------------
module address_segment_policy_table_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // address [47:0], length [95:48], policy [99:96], zero fill
   input  logic [aspt_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // mode [1:0]
   input  logic [1:0]                         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // seg_policy [3:0], seg_id [19:4], bypass_cache [20], home_valid [21],
   // home_node [32:22], zero fill
   output logic [aspt_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // status [1:0]
   output logic [1:0]                         rsp_tuser,
   input  logic                               csr_we,
   input  logic                               csr_index,
   input  logic [9:0]                         csr_wdata
);
   import aspt_pkg::*;

   token_type            tok [ENTRIES+1];
   token_type            fin;
   commit_type           commit;
   result_type           res;
   result_type           rsp_ff, rsp_in;
   result_type           pend_ff, pend_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic                 busy_ff, busy_in;
   logic [15:0]          next_id_ff, next_id_in;
   logic [9:0]           acc_ff, acc_in;
   logic [2:0]           hlog_ff, hlog_in;
   logic                 accept;
   logic                 rsp_take;
   logic [ADDR_BITS-1:0] req_addr;
   logic [ADDR_BITS-1:0] req_len;
   logic [ADDR_BITS-1:0] stripe_full;
   logic [6:0]           stripe;
   logic [7:0]           mask8;

   assign req_tready = !busy_ff && !pend_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign req_addr   = req_tdata[REQ_ADDR_LSB +: ADDR_BITS];
   assign req_len    = req_tdata[REQ_LEN_LSB +: ADDR_BITS];

   always_comb begin
      tok[0]            = '0;
      tok[0].valid      = accept;
      tok[0].mode       = mode_type'(req_tuser);
      tok[0].addr       = req_addr;
      tok[0].seg_end    = {1'b0, req_addr} + {1'b0, req_len};
      tok[0].pol        = req_tdata[REQ_POL_LSB +: 4];
   end

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      aspt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (IDX_BITS'(i)),
         .tok_in   (tok[i]),
         .commit   (commit),
         .tok_out  (tok[i+1])
      );
   end

   assign fin = tok[ENTRIES];

   assign stripe_full = fin.addr >> STRIPE_SHIFT;
   assign stripe      = stripe_full[6:0];
   assign mask8       = (8'd1 << hlog_ff) - 8'd1;

   always_comb begin
      res            = '0;
      res.status     = STATUS_MISS;
      commit.we      = 1'b0;
      commit.idx     = fin.free_idx;
      commit.start   = fin.addr;
      commit.seg_end = fin.seg_end;
      commit.id      = next_id_ff;
      unique case (fin.mode)
         MODE_CREATE: begin
            priority if (fin.overlap) begin
               res.status = STATUS_OVERLAP;
            end else if (!fin.free_found) begin
               res.status = STATUS_FULL;
            end else begin
               res.status = STATUS_OK;
               res.id     = next_id_ff;
               commit.we  = fin.valid;
            end
         end
         MODE_ASSIGN, MODE_LOOKUP: begin
            if (fin.found) begin
               res.status = STATUS_OK;
               res.pol    = fin.hit_pol;
               res.id     = fin.hit_id;
            end
            if (fin.mode == MODE_LOOKUP) begin
               if (res.pol == POL_SUBSCRIPTION) begin
                  res.home_valid = 1'b1;
                  res.home_node  = {1'b0, acc_ff} + {4'b0, stripe & mask8[6:0]};
               end else if (res.pol == POL_ATOMIC_SWAP) begin
                  res.home_valid = 1'b1;
                  res.home_node  = {1'b0, acc_ff};
               end
            end
         end
         default: begin
         end
      endcase
      res.bypass = (res.pol == POL_ATOMIC_UPDATE);
   end

   assign rsp_take = rsp_valid_ff && rsp_tready;

   always_comb begin
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      busy_in       = busy_ff;
      next_id_in    = next_id_ff;
      acc_in        = acc_ff;
      hlog_in       = hlog_ff;
      if (accept) begin
         busy_in = 1'b1;
      end
      if (fin.valid) begin
         busy_in = 1'b0;
         if (!rsp_valid_ff || rsp_take) begin
            rsp_in       = res;
            rsp_valid_in = 1'b1;
         end else begin
            pend_in       = res;
            pend_valid_in = 1'b1;
         end
      end else if (rsp_take) begin
         if (pend_valid_ff) begin
            rsp_in        = pend_ff;
            pend_valid_in = 1'b0;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
      if (commit.we) begin
         next_id_in = next_id_ff + 16'd1;
      end
      if (csr_we) begin
         unique case (csr_index)
            CSR_APP_CORE_COUNT: acc_in  = csr_wdata;
            CSR_HELPER_LOG2:    hlog_in = csr_wdata[2:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         busy_ff       <= 1'b0;
         next_id_ff    <= 16'd0;
         acc_ff        <= 10'd1;
         hlog_ff       <= 3'd0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
         busy_ff       <= busy_in;
         next_id_ff    <= next_id_in;
         acc_ff        <= acc_in;
         hlog_ff       <= hlog_in;
      end
      rsp_ff  <= rsp_in;
      pend_ff <= pend_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = {7'd0, rsp_ff.home_node, rsp_ff.home_valid, rsp_ff.bypass,
                        rsp_ff.id, rsp_ff.pol};

endmodule
